// ===== src/lrgd_pkg.sv =====
package lrgd_pkg;

    localparam int MAX_SAMPLES  = 256;
    localparam int MAX_FEATURES = 8;
    localparam int SI_W  = $clog2(MAX_SAMPLES);
    localparam int FI_W  = $clog2(MAX_FEATURES);
    localparam int FA_W  = SI_W + FI_W;

    localparam logic [2:0] CMD_FEATURE = 3'd0;
    localparam logic [2:0] CMD_TARGET  = 3'd1;
    localparam logic [2:0] CMD_WEIGHT  = 3'd2;
    localparam logic [2:0] CMD_BIAS    = 3'd3;
    localparam logic [2:0] CMD_START   = 3'd4;

    localparam logic [1:0] REG_STEP_RATE     = 2'd0;
    localparam logic [1:0] REG_PASS_COUNT    = 2'd1;
    localparam logic [1:0] REG_SAMPLE_COUNT  = 2'd2;
    localparam logic [1:0] REG_FEATURE_COUNT = 2'd3;

    typedef struct packed {
        logic [2:0]         command;
        logic [7:0]         sample_index;
        logic [2:0]         feature_index;
        logic signed [31:0] value;
    } lrgd_in_t;

    typedef struct packed {
        logic               result_kind;
        logic [2:0]         weight_index;
        logic signed [31:0] trained_value;
        logic               last;
    } lrgd_out_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR_ACC,
        OP_PRED_INIT,
        OP_PRED_MAC,
        OP_ERR,
        OP_GRAD,
        OP_BIAS_GRAD,
        OP_UPD_START,
        OP_UPD_MUL,
        OP_UPD_DIV,
        OP_UPD_WRITE,
        OP_EMIT
    } lrgd_op_t;

    typedef struct packed {
        lrgd_op_t          op;
        logic [SI_W-1:0]   sample;
        logic [FI_W-1:0]   feat;
        logic              is_bias;
        logic              last;
    } lrgd_cmd_t;

    typedef struct packed {
        logic div_done;
    } lrgd_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// ===== src/lrgd_ram.sv =====
module lrgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/lrgd_datapath.sv =====
module lrgd_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load_en,
    input  lrgd_pkg::lrgd_in_t load,
    input  lrgd_pkg::lrgd_cmd_t cmd,
    input  logic [15:0]        step_rate,
    input  logic [8:0]         n_eff,
    output lrgd_pkg::lrgd_stat_t stat,
    output logic               strobe,
    output lrgd_pkg::lrgd_out_t result
);
    import lrgd_pkg::*;

    logic signed [31:0] weight_reg [MAX_FEATURES];
    logic signed [31:0] weight_next [MAX_FEATURES];
    logic signed [31:0] bias_reg, bias_next;
    logic signed [63:0] wacc_reg [MAX_FEATURES];
    logic signed [63:0] wacc_next [MAX_FEATURES];
    logic signed [63:0] bacc_reg, bacc_next;
    logic signed [63:0] sum_reg, sum_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [63:0] prod_reg, prod_next;
    logic               prod_v_reg, prod_v_next;
    logic [FI_W-1:0]    prod_f_reg, prod_f_next;
    logic               prod_g_reg, prod_g_next;
    logic [FI_W-1:0]    feat_d_reg;
    logic               neg_reg, neg_next;
    logic [63:0]        mag_reg, mag_next;
    logic [63:0]        scaled_reg, scaled_next;
    logic [63:0]        quot_reg, quot_next;
    logic [8:0]         rem_reg, rem_next;
    logic [6:0]         dcnt_reg, dcnt_next;
    logic               dbusy_reg, dbusy_next;
    logic               strobe_reg, strobe_next;
    lrgd_out_t          result_reg, result_next;

    logic [31:0] feat_rd;
    logic [31:0] targ_rd;
    logic        fwe, twe;
    logic [FA_W-1:0] faddr_w, faddr_r;

    // Sample memories, loaded by command beats and read by the sequencer.
    assign fwe = load_en && load.command == CMD_FEATURE;
    assign twe = load_en && load.command == CMD_TARGET;
    assign faddr_w = {load.sample_index[SI_W-1:0], load.feature_index[FI_W-1:0]};
    assign faddr_r = {cmd.sample, cmd.feat};

    lrgd_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES * MAX_FEATURES)) u_feat (
        .clk(clk), .we(fwe), .waddr(faddr_w), .wdata(load.value),
        .raddr(faddr_r), .rdata(feat_rd));

    lrgd_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_targ (
        .clk(clk), .we(twe), .waddr(load.sample_index[SI_W-1:0]),
        .wdata(load.value), .raddr(cmd.sample), .rdata(targ_rd));

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic [63:0]        umul;
    logic signed [63:0] step_s;
    logic signed [31:0] param_cur;
    logic [9:0]         rem_sh;
    logic [65:0]        inc_w;

    assign stat.div_done = !dbusy_reg && dcnt_reg == 7'd64;

    always_comb
    begin
        for (int j = 0; j < MAX_FEATURES; j++)
        begin
            weight_next[j] = weight_reg[j];
            wacc_next[j]   = wacc_reg[j];
        end
        bias_next   = bias_reg;
        bacc_next   = bacc_reg;
        sum_next    = sum_reg;
        err_next    = err_reg;
        prod_next   = prod_reg;
        prod_v_next = 1'b0;
        prod_f_next = feat_d_reg;
        prod_g_next = 1'b0;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        scaled_next = scaled_reg;
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        dbusy_next  = dbusy_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        mul_a = '0;
        mul_b = '0;
        umul  = '0;
        rem_sh = '0;
        param_cur = cmd.is_bias ? bias_reg : weight_reg[cmd.feat];
        step_s = '0;
        inc_w = '0;

        // Parameter loads from command beats.
        if (load_en && load.command == CMD_WEIGHT)
        begin
            weight_next[load.feature_index[FI_W-1:0]] = load.value;
        end
        if (load_en && load.command == CMD_BIAS)
        begin
            bias_next = load.value;
        end

        // Registered product from the previous cycle lands in its target.
        if (prod_v_reg)
        begin
            if (prod_g_reg)
            begin
                wacc_next[prod_f_reg] = wacc_reg[prod_f_reg] + (prod_reg >>> 16);
            end
            else
            begin
                sum_next = sum_reg + (prod_reg >>> 16);
            end
        end

        // Bit-serial restoring divider, one quotient bit per cycle.
        if (dbusy_reg)
        begin
            rem_sh = {rem_reg, quot_reg[63]};
            if (rem_sh >= {1'b0, n_eff})
            begin
                rem_next = 9'(rem_sh - {1'b0, n_eff});
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[8:0];
                quot_next = {quot_reg[62:0], 1'b0};
            end
            dcnt_next = dcnt_reg + 7'd1;
            if (dcnt_reg == 7'd63)
            begin
                dbusy_next = 1'b0;
            end
        end

        unique case (cmd.op)
            OP_CLR_ACC:
            begin
                for (int j = 0; j < MAX_FEATURES; j++)
                begin
                    wacc_next[j] = '0;
                end
                bacc_next = '0;
            end
            OP_PRED_INIT:
            begin
                sum_next = 64'(bias_reg);
            end
            OP_PRED_MAC:
            begin
                // The memory word belongs to the feature addressed last cycle.
                mul_a = weight_reg[feat_d_reg];
                mul_b = signed'(feat_rd);
                prod_next = mul_a * mul_b;
                prod_v_next = 1'b1;
            end
            OP_ERR:
            begin
                err_next = sat32(66'(sat32(66'(sum_reg))) - 66'(signed'(targ_rd)));
            end
            OP_GRAD:
            begin
                mul_a = err_reg;
                mul_b = signed'(feat_rd);
                prod_next = mul_a * mul_b;
                prod_v_next = 1'b1;
                prod_g_next = 1'b1;
            end
            OP_BIAS_GRAD:
            begin
                bacc_next = bacc_reg + 64'(err_reg);
            end
            OP_UPD_START:
            begin
                step_s = cmd.is_bias ? bacc_reg : wacc_reg[cmd.feat];
                neg_next = step_s[63];
                mag_next = step_s[63] ? 64'(-step_s) : step_s;
            end
            OP_UPD_MUL:
            begin
                umul = (mag_reg >> 16) * 64'(step_rate);
                scaled_next = umul + (((mag_reg & 64'hFFFF) * 64'(step_rate)) >> 16);
                quot_next  = scaled_next;
                rem_next   = '0;
                dcnt_next  = '0;
                dbusy_next = 1'b1;
            end
            OP_UPD_DIV:
            begin
            end
            OP_UPD_WRITE:
            begin
                step_s = neg_reg ? -signed'(quot_reg) : signed'(quot_reg);
                inc_w = 66'(param_cur) - 66'(step_s);
                if (cmd.is_bias)
                begin
                    bias_next = sat32(signed'(inc_w));
                end
                else
                begin
                    weight_next[cmd.feat] = sat32(signed'(inc_w));
                end
            end
            OP_EMIT:
            begin
                strobe_next = 1'b1;
                result_next.result_kind   = cmd.is_bias;
                result_next.weight_index  = cmd.is_bias ? 3'd0 : 3'(cmd.feat);
                result_next.trained_value = param_cur;
                result_next.last          = cmd.last;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_FEATURES; j++)
            begin
                weight_reg[j] <= '0;
                wacc_reg[j]   <= '0;
            end
            bias_reg   <= '0;
            bacc_reg   <= '0;
            prod_v_reg <= 1'b0;
            dbusy_reg  <= 1'b0;
            dcnt_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            for (int j = 0; j < MAX_FEATURES; j++)
            begin
                weight_reg[j] <= weight_next[j];
                wacc_reg[j]   <= wacc_next[j];
            end
            bias_reg   <= bias_next;
            bacc_reg   <= bacc_next;
            prod_v_reg <= prod_v_next;
            dbusy_reg  <= dbusy_next;
            dcnt_reg   <= dcnt_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        err_reg    <= err_next;
        prod_reg   <= prod_next;
        prod_f_reg <= prod_f_next;
        prod_g_reg <= prod_g_next;
        feat_d_reg <= cmd.feat;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        scaled_reg <= scaled_next;
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    // The divider never runs past its last quotient bit.
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        dbusy_reg |-> dcnt_reg < 7'd64)
        else $error("divider count overran");

    // A product is only pending for one cycle after it is formed.
    a_prod_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        prod_v_reg |-> ($past(cmd.op) == OP_PRED_MAC || $past(cmd.op) == OP_GRAD))
        else $error("stray product");

    // A result beat carries the bias exactly when it is the last one.
    a_last_bias: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> result_reg.last == result_reg.result_kind)
        else $error("last flag not on bias");

endmodule

// ===== src/lrgd_ctrl.sv =====
module lrgd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic [15:0]          pass_count,
    input  logic [8:0]           n_eff,
    input  logic [3:0]           d_eff,
    input  lrgd_pkg::lrgd_stat_t stat,
    output lrgd_pkg::lrgd_cmd_t  cmd,
    output logic                 busy
);
    import lrgd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PASS  = 4'd1;
    localparam logic [3:0] S_PINIT = 4'd2;
    localparam logic [3:0] S_MAC   = 4'd3;
    localparam logic [3:0] S_DRAIN = 4'd4;
    localparam logic [3:0] S_ERR   = 4'd5;
    localparam logic [3:0] S_GRAD  = 4'd6;
    localparam logic [3:0] S_BGRAD = 4'd7;
    localparam logic [3:0] S_USTRT = 4'd8;
    localparam logic [3:0] S_UMUL  = 4'd9;
    localparam logic [3:0] S_UDIV  = 4'd10;
    localparam logic [3:0] S_UWR   = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;

    logic [3:0]  state_reg, state_next;
    logic [15:0] pass_reg, pass_next;
    logic [8:0]  samp_reg, samp_next;
    logic [3:0]  feat_reg, feat_next;
    logic        setup_reg, setup_next;

    // Sequencer: passes, samples within a pass, features within a sample.
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        samp_next  = samp_reg;
        feat_next  = feat_reg;
        setup_next = 1'b0;
        cmd.op      = OP_NONE;
        cmd.sample  = samp_reg[SI_W-1:0];
        cmd.feat    = feat_reg[FI_W-1:0];
        cmd.is_bias = feat_reg == d_eff;
        cmd.last    = feat_reg == d_eff;

        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    pass_next  = '0;
                    samp_next  = '0;
                    feat_next  = '0;
                    state_next = (pass_count == 16'd0) ? S_EMIT : S_PASS;
                end
            end
            S_PASS:
            begin
                cmd.op     = OP_CLR_ACC;
                samp_next  = '0;
                state_next = S_PINIT;
            end
            S_PINIT:
            begin
                cmd.op     = OP_PRED_INIT;
                feat_next  = '0;
                setup_next = 1'b1;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                // The address runs one feature ahead of the product.
                if (setup_reg)
                begin
                    feat_next = feat_reg + 4'd1;
                end
                else
                begin
                    cmd.op = OP_PRED_MAC;
                    if (feat_reg == d_eff)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        feat_next = feat_reg + 4'd1;
                    end
                end
            end
            S_DRAIN:
            begin
                state_next = S_ERR;
            end
            S_ERR:
            begin
                cmd.op     = OP_ERR;
                feat_next  = '0;
                setup_next = 1'b1;
                state_next = S_GRAD;
            end
            S_GRAD:
            begin
                if (setup_reg)
                begin
                    feat_next = feat_reg + 4'd1;
                end
                else
                begin
                    cmd.op = OP_GRAD;
                    if (feat_reg == d_eff)
                    begin
                        state_next = S_BGRAD;
                    end
                    else
                    begin
                        feat_next = feat_reg + 4'd1;
                    end
                end
            end
            S_BGRAD:
            begin
                cmd.op = OP_BIAS_GRAD;
                if (samp_reg == n_eff - 9'd1)
                begin
                    feat_next  = '0;
                    state_next = S_USTRT;
                end
                else
                begin
                    samp_next  = samp_reg + 9'd1;
                    state_next = S_PINIT;
                end
            end
            S_USTRT:
            begin
                cmd.op     = OP_UPD_START;
                state_next = S_UMUL;
            end
            S_UMUL:
            begin
                cmd.op     = OP_UPD_MUL;
                state_next = S_UDIV;
            end
            S_UDIV:
            begin
                cmd.op = OP_UPD_DIV;
                if (stat.div_done)
                begin
                    state_next = S_UWR;
                end
            end
            S_UWR:
            begin
                cmd.op = OP_UPD_WRITE;
                if (feat_reg == d_eff)
                begin
                    feat_next = '0;
                    if (pass_reg == pass_count - 16'd1)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        pass_next  = pass_reg + 16'd1;
                        state_next = S_PASS;
                    end
                end
                else
                begin
                    feat_next  = feat_reg + 4'd1;
                    state_next = S_USTRT;
                end
            end
            S_EMIT:
            begin
                cmd.op = OP_EMIT;
                if (feat_reg == d_eff)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    feat_next = feat_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= '0;
            samp_reg  <= '0;
            feat_reg  <= '0;
            setup_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            samp_reg  <= samp_next;
            feat_reg  <= feat_next;
            setup_reg <= setup_next;
        end
    end

    assign busy = state_reg != S_IDLE;

    // Sample and feature counters stay inside the configured ranges.
    a_samp_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> samp_reg < n_eff && feat_reg <= d_eff)
        else $error("counter out of range");

    // A start beat always leaves the idle state.
    a_go: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && go) |=> state_reg != S_IDLE)
        else $error("start lost");

endmodule

// ===== src/linear_regression_gd_trainer_core.sv =====
// Load beats (feature, target, weight, bias) are accepted while idle; busy stays low.
// A start beat holds busy for pass_count passes over the samples, each followed by an
// update of every parameter through a 64-step serial divider.
// The d + 1 result beats follow one per cycle, the bias last, on the first cycle
// with busy low again. Results are strobed for one cycle and cannot be stalled.
// Reset is asynchronous, active low: control and weight registers reset, memories stay.
module linear_regression_gd_trainer_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  lrgd_pkg::lrgd_in_t   item,
    output logic                 strobe,
    output lrgd_pkg::lrgd_out_t  result,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import lrgd_pkg::*;

    logic [15:0] step_rate_reg, pass_count_reg;
    logic [8:0]  sample_count_reg;
    logic [3:0]  feature_count_reg;
    logic [8:0]  n_eff;
    logic [3:0]  d_eff;
    logic        accept, go;
    lrgd_cmd_t   cmd;
    lrgd_stat_t  stat;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_rate_reg     <= 16'd655;
            pass_count_reg    <= 16'd1000;
            sample_count_reg  <= 9'd4;
            feature_count_reg <= 4'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP_RATE:     step_rate_reg     <= cfg_data;
                REG_PASS_COUNT:    pass_count_reg    <= cfg_data;
                REG_SAMPLE_COUNT:  sample_count_reg  <= cfg_data[8:0];
                REG_FEATURE_COUNT: feature_count_reg <= cfg_data[3:0];
                default:           step_rate_reg     <= step_rate_reg;
            endcase
        end
    end

    // Clamp counts into the supported range.
    always_comb
    begin
        if (sample_count_reg == 9'd0)
            n_eff = 9'd1;
        else if (sample_count_reg > 9'(MAX_SAMPLES))
            n_eff = 9'(MAX_SAMPLES);
        else
            n_eff = sample_count_reg;
        if (feature_count_reg == 4'd0)
            d_eff = 4'd1;
        else if (feature_count_reg > 4'(MAX_FEATURES))
            d_eff = 4'(MAX_FEATURES);
        else
            d_eff = feature_count_reg;
    end

    assign accept = start && !busy;
    assign go     = accept && item.command == CMD_START;

    lrgd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .go(go), .pass_count(pass_count_reg),
        .n_eff(n_eff), .d_eff(d_eff), .stat(stat), .cmd(cmd), .busy(busy));

    lrgd_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .load_en(accept), .load(item), .cmd(cmd),
        .step_rate(step_rate_reg), .n_eff(n_eff), .stat(stat),
        .strobe(strobe), .result(result));

    // No result beat appears while idle with no run in flight.
    a_no_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !$past(busy)) |-> !strobe)
        else $error("result beat while idle");

endmodule
